[src/bls_pkg.sv]
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types, codes and the duty-cycle helper for the backlight sequencer.
// ----------------------------------------------------------------------------
package bls_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SECOND
    } t_state;

    typedef enum logic [1:0] {
        TA_NONE   = 2'd0,
        TA_ARM    = 2'd1,
        TA_CANCEL = 2'd2
    } t_timer_action;

    // configuration register indexes
    localparam logic [1:0] CFG_INIT_BITS         = 2'd0;
    localparam logic [1:0] CFG_REGULATOR_PRESENT = 2'd1;
    localparam logic [1:0] CFG_MAX_DELAY         = 2'd2;

    localparam logic        FUNC_SET  = 1'b0;
    localparam logic        FUNC_FIRE = 1'b1;

    localparam logic [15:0] INIT_BITS_RESET = 16'd0;
    localparam logic        REG_PRESENT_RESET = 1'b1;
    localparam logic [15:0] MAX_DELAY_RESET = 16'd6;

    // level*44/100 == floor(level*14421 / 2^15) for every 8-bit level
    localparam logic [21:0] DUTY_RECIP = 22'd14421;
    localparam int          DUTY_SHIFT = 15;
    localparam int          DUTY_POS   = 5;

    function automatic logic [15:0] duty_word(input logic [7:0] level,
                                              input logic [15:0] init_bits);
        logic [21:0] prod;
        logic [6:0]  duty;
        prod = 22'(level) * DUTY_RECIP;
        duty = prod[DUTY_SHIFT +: 7];
        return (16'(duty) << DUTY_POS) | init_bits;
    endfunction

endpackage

[src/bls_store.sv]
// ----------------------------------------------------------------------------
// bls_store
// Request queue storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bls_store #(
    parameter int DEPTH = 25,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/backlight_request_sequencer_core.sv]
// ----------------------------------------------------------------------------
// backlight_request_sequencer_core
// Orders brightness requests, queues rises and replays them on timer fires.
// ----------------------------------------------------------------------------
//  channel   handshake                   payload
//  input     start / busy                i_func i_level i_now_ticks i_regulator_on
//  config    i_cfg_valid / o_cfg_ready   i_cfg_index i_cfg_data
//  result    o_strobe (one cycle)        o_write_valid o_write_value o_timer_action
//                                        o_timer_delay o_last
//
//  For an item, the accept edge issues the queue read at the read slot and
//  enters EXEC, which updates state and registers the first result. Turning
//  the light off adds the SECOND state for the second write. busy is high from
//  accept until the last result is registered. Reset is synchronous; the
//  queue storage needs no clearing since the pointers bound every read. The
//  receiver cannot stall: each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module backlight_request_sequencer_core #(
    parameter int QUEUE_DEPTH = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic [7:0]  i_level,
    input  logic [31:0] i_now_ticks,
    input  logic        i_regulator_on,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_strobe,
    output logic        o_write_valid,
    output logic [15:0] o_write_value,
    output bls_pkg::t_timer_action o_timer_action,
    output logic [15:0] o_timer_delay,
    output logic        o_last
);
    import bls_pkg::*;

    localparam int          PW        = $clog2(QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
    localparam logic [PW-1:0] ONE_SLOT  = PW'(1);

    // configuration
    logic [15:0] r_init_bits;
    logic        r_reg_present;
    logic [15:0] r_max_delay;

    // sequencer state
    t_state      r_state, n_state;
    logic [PW-1:0] r_read_slot, n_read_slot;
    logic [PW-1:0] r_write_slot, n_write_slot;
    logic [7:0]  r_applied, n_applied;
    logic [31:0] r_stamp, n_stamp;
    logic [15:0] r_step_delay, n_step_delay;
    logic        r_arm_pend, n_arm_pend;

    // latched item
    logic        r_func;
    logic [7:0]  r_level;
    logic [31:0] r_now;
    logic        r_reg_on;

    // result register
    logic          r_strobe, n_strobe;
    logic [15:0]   r_value, n_value;
    t_timer_action r_action, n_action;
    logic [15:0]   r_delay, n_delay;
    logic          r_last, n_last;

    logic          accept;
    logic          store_we;
    logic [7:0]    rd_level;

    bls_store #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (PW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_write_slot),
        .i_wdata (r_level),
        .i_raddr (r_read_slot),
        .o_rdata (rd_level)
    );

    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_bits   <= INIT_BITS_RESET;
            r_reg_present <= REG_PRESENT_RESET;
            r_max_delay   <= MAX_DELAY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_INIT_BITS:         r_init_bits   <= i_cfg_data;
                CFG_REGULATOR_PRESENT: r_reg_present <= i_cfg_data[0];
                CFG_MAX_DELAY:         r_max_delay   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func   <= i_func;
            r_level  <= i_level;
            r_now    <= i_now_ticks;
            r_reg_on <= i_regulator_on;
        end
        r_value <= n_value;
        r_delay <= n_delay;
        r_last  <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_read_slot  <= '0;
            r_write_slot <= '0;
            r_applied    <= 8'd0;
            r_stamp      <= 32'd0;
            r_step_delay <= MAX_DELAY_RESET;
            r_arm_pend   <= 1'b0;
            r_strobe     <= 1'b0;
            r_action     <= TA_NONE;
        end else begin
            r_state      <= n_state;
            r_read_slot  <= n_read_slot;
            r_write_slot <= n_write_slot;
            r_applied    <= n_applied;
            r_stamp      <= n_stamp;
            r_step_delay <= n_step_delay;
            r_arm_pend   <= n_arm_pend;
            r_strobe     <= n_strobe;
            r_action     <= n_action;
        end
    end

    logic          empty;
    logic          enqueue;
    logic          skip;
    logic          more;
    logic [7:0]    lvl;
    logic [PW-1:0] rd_inc;
    logic [PW-1:0] wr_inc;
    logic [31:0]   on_time;

    always_comb begin
        empty   = (r_read_slot == r_write_slot);
        lvl     = (r_func == FUNC_FIRE) ? rd_level : r_level;
        enqueue = (r_func == FUNC_SET) && (r_level > r_applied)
                  && ((r_reg_present && !r_reg_on) || !empty);
        skip    = (r_func == FUNC_FIRE) && empty;
        rd_inc  = (r_read_slot == LAST_SLOT) ? LAST_SLOT : r_read_slot + ONE_SLOT;
        wr_inc  = (r_write_slot == LAST_SLOT) ? LAST_SLOT : r_write_slot + ONE_SLOT;
        more    = (r_func == FUNC_FIRE) && (rd_inc != r_write_slot);
        on_time = r_now - r_stamp;

        n_state      = r_state;
        n_read_slot  = r_read_slot;
        n_write_slot = r_write_slot;
        n_applied    = r_applied;
        n_stamp      = r_stamp;
        n_step_delay = r_step_delay;
        n_arm_pend   = r_arm_pend;
        n_strobe     = 1'b0;
        n_value      = 16'd0;
        n_action     = TA_NONE;
        n_delay      = 16'd0;
        n_last       = 1'b0;
        store_we     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                if (enqueue) begin
                    store_we     = 1'b1;
                    n_write_slot = wr_inc;
                end else if (!skip) begin
                    n_applied = lvl;
                    if (more) begin
                        n_read_slot = rd_inc;
                    end else begin
                        n_read_slot  = '0;
                        n_write_slot = '0;
                    end
                    n_strobe = 1'b1;
                    if (lvl != 8'd0) begin
                        n_stamp = r_now;
                        n_value = duty_word(lvl, r_init_bits);
                        n_last  = 1'b1;
                        if (r_func == FUNC_SET) begin
                            n_action = TA_CANCEL;
                        end else if (more) begin
                            n_action = TA_ARM;
                            n_delay  = r_step_delay;
                        end
                    end else begin
                        // off: learn the on-time, second write follows
                        n_step_delay = (on_time > {16'd0, r_max_delay}) ?
                                       r_max_delay : on_time[15:0];
                        n_value      = r_init_bits;
                        n_action     = (r_func == FUNC_SET) ? TA_CANCEL : TA_NONE;
                        n_arm_pend   = more;
                        n_state      = ST_SECOND;
                    end
                end
            end
            ST_SECOND: begin
                n_state    = ST_IDLE;
                n_strobe   = 1'b1;
                n_last     = 1'b1;
                n_arm_pend = 1'b0;
                if (r_arm_pend) begin
                    n_action = TA_ARM;
                    n_delay  = r_step_delay;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_strobe       = r_strobe;
    assign o_write_valid  = r_strobe;
    assign o_write_value  = r_value;
    assign o_timer_action = r_action;
    assign o_timer_delay  = r_delay;
    assign o_last         = r_last;

    a_slot_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_read_slot <= r_write_slot) && (r_write_slot <= LAST_SLOT))
        else $error("queue slots out of order");

    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> (o_strobe && o_last))
        else $error("first of two writes not followed by the final one");

    a_arm_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_timer_action == TA_ARM)) |-> o_last)
        else $error("timer arm on a non-final word");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after accept");

    a_cancel_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_timer_action == TA_CANCEL)) |-> !$past(r_strobe))
        else $error("cancel on a later word");

endmodule

[test/backlight_request_sequencer_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// backlight_request_sequencer_core_tb
// Drives brightness set requests and step timer fires into the sequencer and
// checks every register write word against a cycle-free model of the request
// queue. A short table of directed items comes first. Then come several
// configuration phases of random queue bursts, off requests and noise, under
// changing sender idling.
// ----------------------------------------------------------------------------
module backlight_request_sequencer_core_tb;
    import bls_pkg::*;

    localparam int QDEPTH      = 25;
    localparam int SETTLE      = 4;
    localparam int END_SETTLE  = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_PHASES    = 6;
    localparam int PHASE_ITEMS = 305;
    localparam int N_ROWS      = 24;

    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic          write_valid;
        logic [15:0]   write_value;
        t_timer_action timer_action;
        logic [15:0]   timer_delay;
        logic          last;
    } bl_write_t;

    // n_typed words are typed in by hand where typed is set
    typedef struct packed {
        logic        func;
        logic [7:0]  level;
        logic [31:0] now;
        logic        reg_on;
        logic        typed;
        logic [1:0]  n_typed;
        bl_write_t   t0;
        bl_write_t   t1;
    } stim_row_t;

    localparam bl_write_t NO_WR = '{1'b0, 16'd0, TA_NONE, 16'd0, 1'b0};

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_func;
    logic [7:0]  i_level;
    logic [31:0] i_now_ticks;
    logic        i_regulator_on;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        o_strobe;
    logic        o_write_valid;
    logic [15:0] o_write_value;
    t_timer_action o_timer_action;
    logic [15:0] o_timer_delay;
    logic        o_last;

    backlight_request_sequencer_core #(
        .QUEUE_DEPTH(QDEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_level       (i_level),
        .i_now_ticks   (i_now_ticks),
        .i_regulator_on(i_regulator_on),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_strobe      (o_strobe),
        .o_write_valid (o_write_valid),
        .o_write_value (o_write_value),
        .o_timer_action(o_timer_action),
        .o_timer_delay (o_timer_delay),
        .o_last        (o_last)
    );

    // sequencer model state
    logic [15:0] cfg_init_bits;
    logic        cfg_reg_present;
    logic [15:0] cfg_max_delay;
    logic [7:0]  level_store [QDEPTH];
    logic [4:0]  rd_slot;
    logic [4:0]  wr_slot;
    logic [7:0]  cur_level;
    logic [31:0] on_stamp;
    logic [15:0] learned_delay;

    bl_write_t   pending_writes [$];
    stim_row_t   stim_rows [N_ROWS];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          items_sent;
    int          idle_pct_now;
    logic [31:0] sim_tick;

    logic [15:0] ph_init [N_PHASES];
    logic        ph_present [N_PHASES];
    logic [15:0] ph_max [N_PHASES];
    int          ph_idle [N_PHASES];

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int apply_brightness(input logic [7:0] lvl, input logic [31:0] now,
                                            output bl_write_t w0, output bl_write_t w1);
        logic [31:0] duty;
        logic [31:0] on_time;
        w0 = '{1'b1, 16'd0, TA_NONE, 16'd0, 1'b0};
        w1 = w0;
        cur_level = lvl;
        if (lvl != 8'd0) begin
            duty = (32'(lvl) * 32'd44) / 32'd100;
            w0.write_value = 16'((duty << 5) | 32'(cfg_init_bits));
            on_stamp = now;
            return 1;
        end
        // off: init bits then zero, and the on-time becomes the step delay
        w0.write_value = cfg_init_bits;
        on_time = now - on_stamp;
        if (on_time > 32'(cfg_max_delay))
            on_time = 32'(cfg_max_delay);
        learned_delay = on_time[15:0];
        return 2;
    endfunction

    function automatic int step_sequencer(input logic func, input logic [7:0] lvl,
                                          input logic [31:0] now, input logic reg_on,
                                          output bl_write_t w0, output bl_write_t w1);
        bl_write_t r [2];
        int        n;
        logic      arm;
        r[0] = NO_WR;
        r[1] = NO_WR;
        w0 = NO_WR;
        w1 = NO_WR;
        if (func == FUNC_FIRE) begin
            if (rd_slot == wr_slot)
                return 0;
            n = apply_brightness(level_store[rd_slot], now, r[0], r[1]);
            if (rd_slot < 5'(QDEPTH - 1))
                rd_slot = rd_slot + 5'd1;
            arm = (rd_slot != wr_slot);
            if (!arm) begin
                rd_slot = 5'd0;
                wr_slot = 5'd0;
            end else begin
                r[n-1].timer_action = TA_ARM;
                r[n-1].timer_delay = learned_delay;
            end
        end else if (lvl > cur_level &&
                     ((cfg_reg_present && !reg_on) || rd_slot != wr_slot)) begin
            level_store[wr_slot] = lvl;
            if (wr_slot < 5'(QDEPTH - 1))
                wr_slot = wr_slot + 5'd1;
            return 0;
        end else begin
            n = apply_brightness(lvl, now, r[0], r[1]);
            r[0].timer_action = TA_CANCEL;
            rd_slot = 5'd0;
            wr_slot = 5'd0;
        end
        r[n-1].last = 1'b1;
        w0 = r[0];
        w1 = r[1];
        return n;
    endfunction

    // every result word is compared with the oldest expected one
    always @(posedge i_clk) begin
        bl_write_t got;
        bl_write_t want;
        if (i_rst_n && o_strobe) begin
            got = '{o_write_valid, o_write_value, o_timer_action, o_timer_delay, o_last};
            if (pending_writes.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("unexpected word: valid=%0b value=%h action=%0d delay=%0d last=%0b",
                             got.write_valid, got.write_value, got.timer_action,
                             got.timer_delay, got.last);
            end else begin
                want = pending_writes.pop_front();
                if (got !== want) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp valid=%0b value=%h action=%0d delay=%0d last=%0b %s",
                                 want.write_valid, want.write_value, want.timer_action,
                                 want.timer_delay, want.last, "");
                    if (mismatch_count <= 10)
                        $display("          got valid=%0b value=%h action=%0d delay=%0d last=%0b",
                                 got.write_valid, got.write_value, got.timer_action,
                                 got.timer_delay, got.last);
                end
            end
        end
    end

    task automatic send_item(input stim_row_t row, input int idle_pct);
        bl_write_t p0;
        bl_write_t p1;
        int        n;
        while ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start = 1'b1;
        i_func = row.func;
        i_level = row.level;
        i_now_ticks = row.now;
        i_regulator_on = row.reg_on;
        do @(posedge i_clk); while (busy);
        n = step_sequencer(row.func, row.level, row.now, row.reg_on, p0, p1);
        if (row.typed) begin
            n = row.n_typed;
            p0 = row.t0;
            p1 = row.t1;
        end
        if (n > 0)
            pending_writes.push_back(p0);
        if (n > 1)
            pending_writes.push_back(p1);
        @(negedge i_clk);
    endtask

    task automatic send_rand(input logic func, input logic [7:0] lvl, input logic reg_on);
        stim_row_t r;
        if ($urandom_range(39) == 0)
            sim_tick = $urandom();
        else
            sim_tick = sim_tick + 32'($urandom_range(0, 12));
        r = '{func, lvl, sim_tick, reg_on, 1'b0, 2'd0, NO_WR, NO_WR};
        send_item(r, idle_pct_now);
        items_sent = items_sent + 1;
    endtask

    task automatic wait_drained(input int settle);
        start = 1'b0;
        do @(posedge i_clk); while (pending_writes.size() != 0 || busy);
        repeat (settle) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_INIT_BITS:         cfg_init_bits = data;
            CFG_REGULATOR_PRESENT: cfg_reg_present = data[0];
            CFG_MAX_DELAY:         cfg_max_delay = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic run_random(input int goal);
        int kind;
        int k;
        int nf;
        int i;
        items_sent = 0;
        while (items_sent < goal) begin
            kind = $urandom_range(99);
            if (kind < 55) begin
                // queue burst: rises above the current level, then fires to drain
                k = ($urandom_range(5) == 0) ? $urandom_range(20, 30) : $urandom_range(1, 8);
                if (cur_level == 8'hFF)
                    send_rand(FUNC_SET, 8'd0, 1'b1);
                for (i = 0; i < k && cur_level != 8'hFF; i++)
                    send_rand(FUNC_SET, 8'($urandom_range(int'(cur_level) + 1, 255)),
                              (i == 0) ? 1'b0 : 1'($urandom_range(1)));
                nf = k + $urandom_range(0, 2);
                for (i = 0; i < nf; i++) begin
                    if ($urandom_range(15) == 0)
                        send_rand(FUNC_SET, 8'($urandom_range(0, int'(cur_level))),
                                  1'($urandom_range(1)));
                    else
                        send_rand(FUNC_FIRE, 8'($urandom), 1'($urandom_range(1)));
                end
            end else if (kind < 70) begin
                send_rand(FUNC_SET, 8'd0, 1'($urandom_range(1)));
            end else if (kind < 80) begin
                send_rand(FUNC_SET, 8'($urandom), 1'b1);
            end else begin
                send_rand(1'($urandom_range(1)), 8'($urandom), 1'($urandom_range(1)));
            end
            if ($urandom_range(149) == 0)
                wait_drained(SETTLE);
        end
    endtask

    initial begin
        int p;
        start = 1'b0;
        i_func = FUNC_SET;
        i_level = 8'd0;
        i_now_ticks = 32'd0;
        i_regulator_on = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_INIT_BITS;
        i_cfg_data = 16'd0;
        i_rst_n = 1'b0;

        cfg_init_bits = INIT_BITS_RESET;
        cfg_reg_present = REG_PRESENT_RESET;
        cfg_max_delay = MAX_DELAY_RESET;
        foreach (level_store[j])
            level_store[j] = 8'd0;
        rd_slot = 5'd0;
        wr_slot = 5'd0;
        cur_level = 8'd0;
        on_stamp = 32'd0;
        learned_delay = MAX_DELAY_RESET;
        sim_tick = 32'd0;

        // first four rows and the final empty fire are typed in by hand
        stim_rows[0]  = '{FUNC_SET, 8'd255, 32'd0, 1'b1, 1'b1, 2'd1,
                          '{1'b1, 16'h0E00, TA_CANCEL, 16'd0, 1'b1}, NO_WR};
        stim_rows[1]  = '{FUNC_SET, 8'd0, 32'd3, 1'b1, 1'b1, 2'd2,
                          '{1'b1, 16'h0000, TA_CANCEL, 16'd0, 1'b0},
                          '{1'b1, 16'h0000, TA_NONE, 16'd0, 1'b1}};
        stim_rows[2]  = '{FUNC_FIRE, 8'hFF, 32'd5, 1'b0, 1'b1, 2'd0, NO_WR, NO_WR};
        stim_rows[3]  = '{FUNC_SET, 8'd1, 32'd10, 1'b0, 1'b1, 2'd0, NO_WR, NO_WR};
        stim_rows[4]  = '{FUNC_SET, 8'd200, 32'd11, 1'b1, 1'b0, 2'd0, NO_WR, NO_WR};
        stim_rows[5]  = '{FUNC_SET, 8'd100, 32'd12, 1'b1, 1'b0, 2'd0, NO_WR, NO_WR};
        stim_rows[6]  = '{FUNC_FIRE, 8'd0, 32'd20, 1'b1, 1'b0, 2'd0, NO_WR, NO_WR};
        stim_rows[7]  = '{FUNC_FIRE, 8'hFF, 32'd25, 1'b0, 1'b0, 2'd0, NO_WR, NO_WR};
        stim_rows[8]  = '{FUNC_FIRE, 8'd0, 32'd30, 1'b1, 1'b0, 2'd0, NO_WR, NO_WR};
        stim_rows[9]  = '{FUNC_SET, 8'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, 2'd0, NO_WR, NO_WR};
        stim_rows[10] = '{FUNC_SET, 8'd50, 32'd0, 1'b0, 1'b0, 2'd0, NO_WR, NO_WR};
        stim_rows[11] = '{FUNC_SET, 8'd0, 32'd1, 1'b0, 1'b0, 2'd0, NO_WR, NO_WR};
        stim_rows[12] = '{FUNC_SET, 8'd255, 32'd2, 1'b0, 1'b0, 2'd0, NO_WR, NO_WR};
        stim_rows[13] = '{FUNC_FIRE, 8'd0, 32'd3, 1'b0, 1'b0, 2'd0, NO_WR, NO_WR};
        stim_rows[14] = '{FUNC_SET, 8'd10, 32'd4, 1'b1, 1'b0, 2'd0, NO_WR, NO_WR};
        stim_rows[15] = '{FUNC_SET, 8'd10, 32'd5, 1'b0, 1'b0, 2'd0, NO_WR, NO_WR};
        stim_rows[16] = '{FUNC_SET, 8'd0, 32'h8000_0000, 1'b1, 1'b0, 2'd0, NO_WR, NO_WR};
        stim_rows[17] = '{FUNC_SET, 8'd128, 32'd8, 1'b0, 1'b0, 2'd0, NO_WR, NO_WR};
        stim_rows[18] = '{FUNC_SET, 8'd0, 32'd9, 1'b1, 1'b0, 2'd0, NO_WR, NO_WR};
        stim_rows[19] = '{FUNC_SET, 8'd128, 32'd10, 1'b0, 1'b0, 2'd0, NO_WR, NO_WR};
        stim_rows[20] = '{FUNC_SET, 8'd129, 32'd11, 1'b1, 1'b0, 2'd0, NO_WR, NO_WR};
        stim_rows[21] = '{FUNC_FIRE, 8'd0, 32'd12, 1'b1, 1'b0, 2'd0, NO_WR, NO_WR};
        stim_rows[22] = '{FUNC_FIRE, 8'd0, 32'd14, 1'b1, 1'b0, 2'd0, NO_WR, NO_WR};
        stim_rows[23] = '{FUNC_FIRE, 8'd0, 32'd15, 1'b1, 1'b1, 2'd0, NO_WR, NO_WR};

        ph_init[0] = 16'h0000;          ph_present[0] = 1'b1; ph_max[0] = 16'd15;
        ph_init[1] = 16'hFFFF;          ph_present[1] = 1'b1; ph_max[1] = 16'hFFFF;
        ph_init[2] = 16'($urandom);     ph_present[2] = 1'b0; ph_max[2] = 16'd0;
        ph_init[3] = 16'($urandom);     ph_present[3] = 1'b1; ph_max[3] = 16'd1;
        ph_init[4] = 16'($urandom);     ph_present[4] = 1'b1;
        ph_max[4] = 16'($urandom_range(0, 40));
        ph_init[5] = 16'h8000;          ph_present[5] = 1'($urandom_range(1));
        ph_max[5] = 16'd3;
        ph_idle[0] = 15; ph_idle[1] = 15;
        ph_idle[2] = 78; ph_idle[3] = 78;
        ph_idle[4] = 0;  ph_idle[5] = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (stim_rows[r])
            send_item(stim_rows[r], 15);

        for (p = 0; p < N_PHASES; p++) begin
            wait_drained(SETTLE);
            write_reg(CFG_INIT_BITS, ph_init[p]);
            // upper data bits of the one-bit register are don't-care
            write_reg(CFG_REGULATOR_PRESENT, {15'($urandom), ph_present[p]});
            write_reg(CFG_MAX_DELAY, ph_max[p]);
            if (p == 2)
                write_reg(CFG_UNUSED, 16'($urandom));
            idle_pct_now = ph_idle[p];
            run_random(PHASE_ITEMS);
        end

        wait_drained(END_SETTLE);
        if (mismatch_count == 0 && pending_writes.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
src/bls_pkg.sv
src/bls_store.sv
src/backlight_request_sequencer_core.sv
test/backlight_request_sequencer_core_tb.sv
